/* src/dja_pkg.sv */
// Shared types and constants for the dual joint PID controller.
`default_nettype none
package dja_pkg;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD,
        OP_ERR,
        OP_MP,
        OP_P,
        OP_MI,
        OP_ML,
        OP_MH,
        OP_AH,
        OP_IDIV,
        OP_INC,
        OP_MD,
        OP_DL,
        OP_DH,
        OP_DDIV,
        OP_D,
        OP_OUT,
        OP_EMIT
    } t_op;

    typedef struct packed {
        t_op  op;
        logic joint;
    } t_cmd;

    typedef struct packed {
        logic div_busy;
        logic dt_small;
        logic out_free;
    } t_sts;

    localparam logic [2:0] REG_KP     = 3'd0;
    localparam logic [2:0] REG_KI     = 3'd1;
    localparam logic [2:0] REG_KD     = 3'd2;
    localparam logic [2:0] REG_IMAX   = 3'd3;
    localparam logic [2:0] REG_IMIN   = 3'd4;
    localparam logic [2:0] REG_FLIM   = 3'd5;
    localparam logic [2:0] REG_STROKE = 3'd6;

    localparam int          DIV_W        = 72;
    localparam int          DIV_STEPS    = 36;
    localparam logic [19:0] DT_DEFAULT   = 20'd1000;
    localparam logic [20:0] DT_MAX       = 21'd1000000;
    localparam logic [20:0] IDIV_DIVISOR = 21'd1000000;
    localparam logic [31:0] D_SCALE      = 32'd15625;

endpackage
`default_nettype wire

/* src/dja_div.sv */
// Radix-4 restoring divider, 72-bit dividend by 21-bit divisor.
`default_nettype none
module dja_div (
    input  wire logic                    i_clk,
    input  wire logic                    i_rst_n,
    input  wire logic                    i_start,
    input  wire logic [dja_pkg::DIV_W-1:0] i_dividend,
    input  wire logic [20:0]             i_divisor,
    output logic                         o_busy,
    output logic [dja_pkg::DIV_W-1:0]    o_quotient
);
    import dja_pkg::*;

    logic [DIV_W-1:0] r_q;
    logic [20:0]      r_rem;
    logic [20:0]      r_div;
    logic [5:0]       r_cnt;
    logic             r_busy;

    logic [21:0] t1, t2;
    logic [20:0] rem1, rem2;
    logic        b1, b2;

    always_comb begin
        t1 = {r_rem, r_q[DIV_W-1]};
        b1 = (t1 >= {1'b0, r_div});
        rem1 = b1 ? 21'(t1 - {1'b0, r_div}) : t1[20:0];
        t2 = {rem1, r_q[DIV_W-2]};
        b2 = (t2 >= {1'b0, r_div});
        rem2 = b2 ? 21'(t2 - {1'b0, r_div}) : t2[20:0];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_cnt  <= '0;
        end else if (i_start) begin
            r_busy <= 1'b1;
            r_cnt  <= '0;
        end else if (r_busy) begin
            r_cnt <= 6'(r_cnt + 6'd1);
            if (r_cnt == 6'(DIV_STEPS - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_q   <= i_dividend;
            r_rem <= '0;
            r_div <= i_divisor;
        end else if (r_busy) begin
            r_q   <= {r_q[DIV_W-3:0], b1, b2};
            r_rem <= rem2;
        end
    end

    assign o_busy     = r_busy;
    assign o_quotient = r_q;
endmodule
`default_nettype wire

/* src/dja_dp.sv */
// Datapath: configuration, joint state, shared multiplier and divider, output register.
`default_nettype none
module dja_dp (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire dja_pkg::t_cmd i_cmd,
    output dja_pkg::t_sts      o_sts,
    input  wire logic [95:0]   i_s_tdata,
    input  wire logic          i_cfg_valid,
    input  wire logic [2:0]    i_cfg_index,
    input  wire logic [31:0]   i_cfg_data,
    output logic               o_m_tvalid,
    input  wire logic          i_m_tready,
    output logic [87:0]        o_m_tdata
);
    import dja_pkg::*;

    logic [31:0]        r_kp, r_ki, r_kd;
    logic signed [31:0] r_imax, r_imin;
    logic [30:0]        r_flim;
    logic [22:0]        r_stroke;
    logic signed [31:0] r_int [2];
    logic signed [24:0] r_prev [2];
    logic               r_pend;

    logic signed [23:0] r_pos [2];
    logic [22:0]        r_cmdc;
    logic [19:0]        r_dt;
    logic               r_rstd;
    logic signed [24:0] r_err;
    logic signed [25:0] r_de;
    logic [63:0]        r_prod;
    logic [57:0]        r_m;
    logic [77:0]        r_acc;
    logic signed [37:0] r_p;
    logic signed [31:0] r_cand;
    logic signed [41:0] r_d;
    logic [31:0]        r_force [2];
    logic               r_ovalid;
    logic [87:0]        r_odata;

    logic               j;
    logic signed [23:0] cmd_in;
    logic [22:0]        cmdc_c;
    logic [20:0]        dt_in;
    logic [19:0]        dt_c;
    logic signed [24:0] tgt, err_c;
    logic signed [25:0] de_c;
    logic [24:0]        err_mag;
    logic [25:0]        de_mag;
    logic [31:0]        mul_a, mul_b;
    logic [63:0]        mul_p;
    logic signed [37:0] pm_s, p_c;
    logic               div_start, div_busy;
    logic [DIV_W-1:0]   div_dividend, div_q;
    logic [20:0]        div_divisor;
    logic signed [39:0] inc_s;
    logic signed [40:0] isum, iclamp;
    logic signed [31:0] cand_c;
    logic [40:0]        dv;
    logic signed [41:0] dv_s, d_c;
    logic signed [43:0] raw, flim_s, force_c;
    logic               deeper, dt_small;

    assign j = i_cmd.joint;

    always_comb begin
        cmd_in = $signed(i_s_tdata[23:0]);
        if (cmd_in[23]) begin
            cmdc_c = '0;
        end else if (cmd_in[22:0] > r_stroke) begin
            cmdc_c = r_stroke;
        end else begin
            cmdc_c = cmd_in[22:0];
        end
        dt_in = i_s_tdata[92:72];
        dt_c = (dt_in != '0 && dt_in <= DT_MAX) ? dt_in[19:0] : DT_DEFAULT;

        tgt = $signed({2'b00, r_cmdc});
        if (!j) begin
            tgt = -tgt;
        end
        err_c = tgt - 25'(r_pos[j]);
        de_c = r_rstd ? 26'sd0 : 26'(err_c) - 26'(r_prev[j]);

        err_mag = r_err[24] ? 25'(-r_err) : 25'(r_err);
        de_mag  = r_de[25] ? 26'(-r_de) : 26'(r_de);

        unique case (i_cmd.op)
            OP_MP:   begin mul_a = 32'(err_mag);     mul_b = r_kp;        end
            OP_MI:   begin mul_a = 32'(err_mag);     mul_b = r_ki;        end
            OP_MD:   begin mul_a = 32'(de_mag);      mul_b = r_kd;        end
            OP_ML:   begin mul_a = r_m[31:0];        mul_b = 32'(r_dt);   end
            OP_MH:   begin mul_a = 32'(r_m[57:32]);  mul_b = 32'(r_dt);   end
            OP_DL:   begin mul_a = r_m[31:0];        mul_b = D_SCALE;     end
            OP_DH:   begin mul_a = 32'(r_m[57:32]);  mul_b = D_SCALE;     end
            default: begin mul_a = '0;               mul_b = '0;          end
        endcase
        mul_p = mul_a * mul_b;

        pm_s = $signed({1'b0, r_prod[56:20]});
        p_c  = r_err[24] ? -pm_s : pm_s;

        div_start    = (i_cmd.op == OP_IDIV) || (i_cmd.op == OP_DDIV);
        div_dividend = (i_cmd.op == OP_IDIV) ? DIV_W'(r_acc[77:20]) : r_acc[71:0];
        div_divisor  = (i_cmd.op == OP_IDIV) ? IDIV_DIVISOR : 21'(r_dt);

        inc_s = $signed({1'b0, div_q[38:0]});
        if (r_err[24]) begin
            inc_s = -inc_s;
        end
        isum = 41'(r_int[j]) + 41'(inc_s);
        iclamp = isum;
        if (iclamp > 41'(r_imax)) begin
            iclamp = 41'(r_imax);
        end
        if (iclamp < 41'(r_imin)) begin
            iclamp = 41'(r_imin);
        end
        cand_c = (r_ki == '0) ? 32'sd0 : 32'(iclamp);

        dt_small = (r_dt <= 20'd1);
        dv = (|div_q[71:54]) ? (41'd1 << 40) : {1'b0, div_q[53:14]};
        dv_s = $signed({1'b0, dv});
        if (dt_small) begin
            d_c = '0;
        end else begin
            d_c = r_de[25] ? -dv_s : dv_s;
        end

        raw    = 44'(r_p) + 44'(r_cand) + 44'(r_d);
        flim_s = $signed({13'b0, r_flim});
        if (raw > flim_s) begin
            force_c = flim_s;
        end else if (raw < -flim_s) begin
            force_c = -flim_s;
        end else begin
            force_c = raw;
        end
        deeper = (raw > flim_s && !r_err[24] && r_err != '0) || (raw < -flim_s && r_err[24]);
    end

    dja_div u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (div_dividend),
        .i_divisor  (div_divisor),
        .o_busy     (div_busy),
        .o_quotient (div_q)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_kp     <= 32'd65536000;
            r_ki     <= 32'd13107200;
            r_kd     <= 32'd196608;
            r_imax   <= 32'sd131072000;
            r_imin   <= -32'sd131072000;
            r_flim   <= 31'd655360000;
            r_stroke <= 23'd219152;
            r_int[0] <= '0;
            r_int[1] <= '0;
            r_prev[0] <= '0;
            r_prev[1] <= '0;
            r_pend   <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            if (i_cfg_valid) begin
                unique case (i_cfg_index)
                    REG_KP: r_kp <= i_cfg_data;
                    REG_KI: begin
                        r_ki <= i_cfg_data;
                        if (i_cfg_data == '0) begin
                            r_int[0] <= '0;
                            r_int[1] <= '0;
                        end
                    end
                    REG_KD: begin
                        r_kd   <= i_cfg_data;
                        r_pend <= 1'b1;
                    end
                    REG_IMAX:   r_imax   <= $signed(i_cfg_data);
                    REG_IMIN:   r_imin   <= $signed(i_cfg_data);
                    REG_FLIM:   r_flim   <= i_cfg_data[30:0];
                    REG_STROKE: r_stroke <= i_cfg_data[22:0];
                    default: ;
                endcase
            end
            if (i_cmd.op == OP_LOAD) begin
                r_pend <= 1'b0;
            end
            if (i_cmd.op == OP_OUT) begin
                if (r_ki == '0) begin
                    r_int[j] <= '0;
                end else if (!deeper) begin
                    r_int[j] <= r_cand;
                end
                r_prev[j] <= r_err;
            end
            if (i_cmd.op == OP_EMIT) begin
                r_ovalid <= 1'b1;
            end else if (i_m_tready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            OP_LOAD: begin
                r_pos[0] <= $signed(i_s_tdata[47:24]);
                r_pos[1] <= $signed(i_s_tdata[71:48]);
                r_cmdc   <= cmdc_c;
                r_dt     <= dt_c;
                r_rstd   <= r_pend;
            end
            OP_ERR: begin
                r_err <= err_c;
                r_de  <= de_c;
            end
            OP_MP, OP_MH, OP_DH: r_prod <= mul_p;
            OP_P:                r_p    <= p_c;
            OP_MI, OP_MD:        r_m    <= mul_p[57:0];
            OP_ML, OP_DL:        r_acc  <= 78'(mul_p);
            OP_AH:               r_acc  <= r_acc + {r_prod[45:0], 32'b0};
            OP_INC:              r_cand <= cand_c;
            OP_D:                r_d    <= d_c;
            OP_OUT:              r_force[j] <= force_c[31:0];
            OP_EMIT:             r_odata <= {r_pos[0], r_force[1], r_force[0]};
            default: ;
        endcase
    end

    assign o_sts.div_busy = div_busy;
    assign o_sts.dt_small = dt_small;
    assign o_sts.out_free = !r_ovalid || i_m_tready;
    assign o_m_tvalid     = r_ovalid;
    assign o_m_tdata      = r_odata;
endmodule
`default_nettype wire

/* src/dja_ctrl.sv */
// Controller: sequences the per-joint PID steps over the datapath.
`default_nettype none
module dja_ctrl (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_s_tvalid,
    output logic               o_s_tready,
    input  wire dja_pkg::t_sts i_sts,
    output dja_pkg::t_cmd      o_cmd
);
    import dja_pkg::*;

    typedef enum logic [4:0] {
        S_IDLE, S_ERR, S_MP, S_P, S_MI, S_ML, S_MH, S_AHI, S_IDIV, S_IWAIT,
        S_INC, S_MD, S_DL, S_DH, S_AHD, S_DDIV, S_DWAIT, S_D, S_OUT, S_DONE
    } t_state;

    t_state r_state;
    logic   r_joint;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_joint <= 1'b0;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    r_joint <= 1'b0;
                    if (i_s_tvalid) begin
                        r_state <= S_ERR;
                    end
                end
                S_ERR:   r_state <= S_MP;
                S_MP:    r_state <= S_P;
                S_P:     r_state <= S_MI;
                S_MI:    r_state <= S_ML;
                S_ML:    r_state <= S_MH;
                S_MH:    r_state <= S_AHI;
                S_AHI:   r_state <= S_IDIV;
                S_IDIV:  r_state <= S_IWAIT;
                S_IWAIT: if (!i_sts.div_busy) r_state <= S_INC;
                S_INC:   r_state <= i_sts.dt_small ? S_D : S_MD;
                S_MD:    r_state <= S_DL;
                S_DL:    r_state <= S_DH;
                S_DH:    r_state <= S_AHD;
                S_AHD:   r_state <= S_DDIV;
                S_DDIV:  r_state <= S_DWAIT;
                S_DWAIT: if (!i_sts.div_busy) r_state <= S_D;
                S_D:     r_state <= S_OUT;
                S_OUT: begin
                    if (!r_joint) begin
                        r_joint <= 1'b1;
                        r_state <= S_ERR;
                    end else begin
                        r_state <= S_DONE;
                    end
                end
                S_DONE:  if (i_sts.out_free) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_cmd.joint = r_joint;
        unique case (r_state)
            S_IDLE:  o_cmd.op = i_s_tvalid ? OP_LOAD : OP_NOP;
            S_ERR:   o_cmd.op = OP_ERR;
            S_MP:    o_cmd.op = OP_MP;
            S_P:     o_cmd.op = OP_P;
            S_MI:    o_cmd.op = OP_MI;
            S_ML:    o_cmd.op = OP_ML;
            S_MH:    o_cmd.op = OP_MH;
            S_AHI:   o_cmd.op = OP_AH;
            S_IDIV:  o_cmd.op = OP_IDIV;
            S_INC:   o_cmd.op = OP_INC;
            S_MD:    o_cmd.op = OP_MD;
            S_DL:    o_cmd.op = OP_DL;
            S_DH:    o_cmd.op = OP_DH;
            S_AHD:   o_cmd.op = OP_AH;
            S_DDIV:  o_cmd.op = OP_DDIV;
            S_D:     o_cmd.op = OP_D;
            S_OUT:   o_cmd.op = OP_OUT;
            S_DONE:  o_cmd.op = i_sts.out_free ? OP_EMIT : OP_NOP;
            default: o_cmd.op = OP_NOP;
        endcase
    end

    assign o_s_tready = (r_state == S_IDLE);
endmodule
`default_nettype wire

/* src/dual_joint_pid_antiwindup.sv */
// Top level of the two-joint gripper PID controller with anti-windup.
//
// Input stream (i_s_*): one beat per control tick carrying command,
// left and right joint positions and the elapsed time in microseconds.
// Output stream (o_m_*): one beat per tick with both saturated forces and
// an echo of the left position.
// Config channel (i_cfg_*): register index and 32-bit data; always ready.
// Write only while no tick is in flight.
// When the elapsed time is 1 us the derivative multiply and division are
// skipped. Per joint, the 72-bit divisions run on one shared divider
// (issue, 36 steps at two quotient bits a cycle, hand-off) and the
// multiply, add and update steps run on one shared 32x32 multiplier; an
// emit step then moves the result to the output register. The next beat is
// taken only once the previous tick sits in the output register; a stalled
// receiver holds one finished result while the next tick runs, which then
// waits with its result until the register frees.
// Reset loads the default gains and limits and clears integral state,
// previous errors, the derivative-reset flag and the output valid.
`default_nettype none
module dual_joint_pid_antiwindup (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_s_tvalid,
    output logic             o_s_tready,
    // [23:0] command, [47:24] left_position, [71:48] right_position,
    // [92:72] elapsed_us, [95:93] zero
    input  wire logic [95:0] i_s_tdata,
    output logic             o_m_tvalid,
    input  wire logic        i_m_tready,
    // [31:0] left_force, [63:32] right_force, [87:64] reported_position
    output logic [87:0]      o_m_tdata,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [2:0]  i_cfg_index,
    input  wire logic [31:0] i_cfg_data
);
    import dja_pkg::*;

    t_cmd cmd;
    t_sts sts;

    dja_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (i_s_tvalid),
        .o_s_tready (o_s_tready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    dja_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (cmd),
        .o_sts       (sts),
        .i_s_tdata   (i_s_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_m_tvalid  (o_m_tvalid),
        .i_m_tready  (i_m_tready),
        .o_m_tdata   (o_m_tdata)
    );

    assign o_cfg_ready = 1'b1;
endmodule
`default_nettype wire
